### rtl/rgbhsv_pkg.sv
package rgbhsv_pkg;

   // channel and result widths
   localparam int ChW   = 8;
   localparam int HueW  = 9;
   localparam int PctW  = 7;
   // dividend width: 255 * 100 = 25500 fits 15 bits
   localparam int NumW  = 15;
   // quotient bits: every quotient here is at most 100
   localparam int QuoW  = 7;
   localparam int Lanes = 3;

   localparam int Percent    = 100;
   localparam int FullCircle = 360;
   localparam int OffGreen   = 120;
   localparam int OffBlue    = 240;
   // 60/100 reduces to 3/5, and z/5 == (z*205) >> 10 for z below 1024
   localparam int DegNum     = 3;
   localparam int RecipFive  = 205;
   localparam int RecipShift = 10;

   // lane assignment of the shared divider pipeline
   localparam int LaneSat = 0;
   localparam int LaneHa  = 1;
   localparam int LaneHb  = 2;

   typedef enum logic [1:0] {
      BR_RED,
      BR_GREEN,
      BR_BLUE
   } branch_type;

   typedef struct packed {
      logic                dark;
      logic                grey;
      branch_type          branch;
      logic [PctW-1:0]     value;
   } side_type;

   typedef struct packed {
      logic [NumW-1:0]     rem;
      logic [ChW-1:0]      den;
      logic [QuoW-1:0]     quo;
   } lane_type;

   typedef struct packed {
      side_type                  side;
      lane_type [Lanes-1:0]      lane;
   } div_word_type;

   function automatic logic [NumW-1:0] times_pct(input logic [ChW-1:0] x);
      return NumW'(x) * NumW'(Percent);
   endfunction

   // exact x/255 for x up to 32639
   function automatic logic [PctW-1:0] div255(input logic [NumW-1:0] x);
      logic [NumW:0] t;
      t = {1'b0, x} + (NumW+1)'(x >> 8) + (NumW+1)'(1);
      return t[PctW+7:8];
   endfunction

endpackage

### rtl/rgbhsv_front.sv
module rgbhsv_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rgbhsv_pkg::ChW-1:0]   req_red,
   input  logic [rgbhsv_pkg::ChW-1:0]   req_green,
   input  logic [rgbhsv_pkg::ChW-1:0]   req_blue,
   output logic                         out_valid,
   input  logic                         out_ready,
   output rgbhsv_pkg::div_word_type     out_word
);
   import rgbhsv_pkg::*;

   logic [ChW-1:0]  top;
   logic [ChW-1:0]  bot;
   logic [ChW-1:0]  span;
   logic [ChW-1:0]  xa;
   logic [ChW-1:0]  xb;
   logic [PctW-1:0] value;
   branch_type      branch;
   div_word_type    word_in;
   div_word_type    word_ff;
   logic            valid_in;
   logic            valid_ff;

   always_comb begin
      top = req_red;
      if (req_green > top) top = req_green;
      if (req_blue > top)  top = req_blue;
      bot = req_red;
      if (req_green < bot) bot = req_green;
      if (req_blue < bot)  bot = req_blue;
      span  = top - bot;
      value = div255(times_pct(top));

      // first channel equal to the max picks the branch
      if (req_red == top) begin
         branch = BR_RED;
      end else if (req_green == top) begin
         branch = BR_GREEN;
      end else begin
         branch = BR_BLUE;
      end

      case (branch)
         BR_RED: begin
            xa = req_blue;
            xb = req_green;
         end
         BR_GREEN: begin
            xa = req_red;
            xb = req_blue;
         end
         BR_BLUE: begin
            xa = req_green;
            xb = req_red;
         end
         default: begin
            xa = req_blue;
            xb = req_green;
         end
      endcase

      word_in.side.dark   = (value == '0);
      word_in.side.grey   = (span == '0);
      word_in.side.branch = branch;
      word_in.side.value  = value;
      word_in.lane[LaneSat] = '{rem: times_pct(span),     den: top,  quo: '0};
      word_in.lane[LaneHa]  = '{rem: times_pct(top - xa), den: span, quo: '0};
      word_in.lane[LaneHb]  = '{rem: times_pct(top - xb), den: span, quo: '0};
   end

   assign req_ready = !valid_ff || out_ready;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### rtl/rgbhsv_div.sv
module rgbhsv_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  rgbhsv_pkg::div_word_type     in_word,
   output logic                         out_valid,
   input  logic                         out_ready,
   output rgbhsv_pkg::div_word_type     out_word
);
   import rgbhsv_pkg::*;

   // chain[k] feeds stage k, chain[QuoW] is the output
   logic                vld [QuoW+1];
   logic                rdy [QuoW+1];
   div_word_type        wrd [QuoW+1];
   logic                valid_ff [QuoW];
   div_word_type        word_ff  [QuoW];

   assign vld[0]    = in_valid;
   assign wrd[0]    = in_word;
   assign in_ready  = rdy[0];
   assign rdy[QuoW] = out_ready;
   assign out_valid = vld[QuoW];
   assign out_word  = wrd[QuoW];

   for (genvar k = 0; k < QuoW; k++) begin : g_stage
      // one restoring step per stage, msb of the quotient first
      localparam int Bit = QuoW - 1 - k;
      div_word_type word_in;
      logic         valid_in;

      always_comb begin
         word_in = wrd[k];
         for (int n = 0; n < Lanes; n++) begin
            if (wrd[k].lane[n].rem >= (NumW'(wrd[k].lane[n].den) << Bit)) begin
               word_in.lane[n].rem      = wrd[k].lane[n].rem
                                          - (NumW'(wrd[k].lane[n].den) << Bit);
               word_in.lane[n].quo[Bit] = 1'b1;
            end
         end
      end

      assign rdy[k]   = !valid_ff[k] || rdy[k+1];
      assign valid_in = rdy[k] ? vld[k] : valid_ff[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (vld[k] && rdy[k]) begin
            word_ff[k] <= word_in;
         end
      end

      assign vld[k+1] = valid_ff[k];
      assign wrd[k+1] = word_ff[k];
   end

   // partial remainder out of each stage stays below the divisor at that stage's bit weight
   for (genvar k = 0; k < QuoW; k++) begin : g_check
      localparam int Bit = QuoW - 1 - k;
      for (genvar n = 0; n < Lanes; n++) begin : g_lane
         a_rem_bound: assert property (@(posedge clock) disable iff (reset)
            valid_ff[k] && word_ff[k].lane[n].den != '0
            |-> word_ff[k].lane[n].rem < (NumW'(word_ff[k].lane[n].den) << Bit))
            else $error("divider remainder out of range");
      end
   end

endmodule

### rtl/rgbhsv_back.sv
module rgbhsv_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  rgbhsv_pkg::div_word_type     in_word,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rgbhsv_pkg::HueW-1:0]  rsp_hue,
   output logic [rgbhsv_pkg::PctW-1:0]  rsp_saturation,
   output logic [rgbhsv_pkg::PctW-1:0]  rsp_brightness_value
);
   import rgbhsv_pkg::*;

   typedef struct packed {
      side_type          side;
      logic              neg;
      logic [HueW-1:0]   z;
      logic [PctW-1:0]   sat;
   } mid_type;

   logic signed [QuoW:0]  diff;
   logic [QuoW:0]         mag;
   mid_type               mid_in;
   mid_type               mid_ff;
   logic                  mid_valid_in;
   logic                  mid_valid_ff;
   logic                  mid_ready;

   logic [15:0]           prod;
   logic [5:0]            q;
   logic [HueW-1:0]       hue;
   logic [HueW-1:0]       hue_in;
   logic [PctW-1:0]       sat_in;
   logic [PctW-1:0]       val_in;
   logic [HueW-1:0]       hue_ff;
   logic [PctW-1:0]       sat_ff;
   logic [PctW-1:0]       val_ff;
   logic                  rsp_valid_in;
   logic                  rsp_valid_ff;
   logic                  out_ready;

   // stage 1: term difference, magnitude times 3
   always_comb begin
      diff = $signed({1'b0, in_word.lane[LaneHa].quo})
             - $signed({1'b0, in_word.lane[LaneHb].quo});
      mag  = diff[QuoW] ? QuoW'(0) - diff : diff;
      mid_in.side = in_word.side;
      mid_in.neg  = diff[QuoW];
      mid_in.z    = HueW'(mag) * HueW'(DegNum);
      mid_in.sat  = in_word.lane[LaneSat].quo;
   end

   assign in_ready     = !mid_valid_ff || mid_ready;
   assign mid_valid_in = in_ready ? in_valid : mid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mid_ff <= mid_in;
      end
   end

   // stage 2: divide by 5, add the sector offset, wrap, special cases
   always_comb begin
      prod = 16'(mid_ff.z) * 16'(RecipFive);
      q    = prod[RecipShift+5:RecipShift];
      case (mid_ff.side.branch)
         BR_RED: begin
            hue = (mid_ff.neg && q != '0) ? HueW'(FullCircle) - HueW'(q) : HueW'(q);
         end
         BR_GREEN: begin
            hue = mid_ff.neg ? HueW'(OffGreen) - HueW'(q) : HueW'(OffGreen) + HueW'(q);
         end
         BR_BLUE: begin
            hue = mid_ff.neg ? HueW'(OffBlue) - HueW'(q) : HueW'(OffBlue) + HueW'(q);
         end
         default: begin
            hue = '0;
         end
      endcase

      if (mid_ff.side.dark) begin
         hue_in = '0;
         sat_in = '0;
         val_in = '0;
      end else if (mid_ff.side.grey) begin
         hue_in = '0;
         sat_in = '0;
         val_in = mid_ff.side.value;
      end else begin
         hue_in = hue;
         sat_in = mid_ff.sat;
         val_in = mid_ff.side.value;
      end
   end

   assign out_ready    = !rsp_valid_ff || rsp_ready;
   assign mid_ready    = out_ready;
   assign rsp_valid_in = out_ready ? mid_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_valid_ff && out_ready) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         val_ff <= val_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hue              = hue_ff;
   assign rsp_saturation       = sat_ff;
   assign rsp_brightness_value = val_ff;

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> hue_ff < HueW'(FullCircle) && sat_ff <= PctW'(Percent)
                       && val_ff <= PctW'(Percent))
      else $error("result word out of range");

   a_dark_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && val_ff == '0 |-> hue_ff == '0 && sat_ff == '0)
      else $error("dark pixel with nonzero hue or saturation");

endmodule

### rtl/rgb_to_hsv_integer.sv
// rgb to hsv converter, one 8-bit rgb pixel in, one hsv word out
//
// req channel: req_red, req_green, req_blue, taken when req_valid and
// req_ready are high at a clock edge
// rsp channel: rsp_hue (0..359 degrees), rsp_saturation and
// rsp_brightness_value (0..100 percent), handed over when rsp_valid and
// rsp_ready are high
//
// the accepted word passes 10 register stages (1 front, 7 divider at one
// quotient bit each, 2 output) to rsp_valid; throughput: one word per clock
// while the receiver is ready, set by the one-bit-per-stage divider lanes
// (saturation and both hue terms divide side by side)
//
// each stage holds its own valid bit and is ready when empty or when the
// stage after it moves, so a stalled receiver lets the pipe fill up to
// 10 words before req_ready drops; bubbles are squeezed out
// reset (synchronous) empties every stage, no payload is cleared
module rgb_to_hsv_integer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rgbhsv_pkg::ChW-1:0]   req_red,
   input  logic [rgbhsv_pkg::ChW-1:0]   req_green,
   input  logic [rgbhsv_pkg::ChW-1:0]   req_blue,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rgbhsv_pkg::HueW-1:0]  rsp_hue,
   output logic [rgbhsv_pkg::PctW-1:0]  rsp_saturation,
   output logic [rgbhsv_pkg::PctW-1:0]  rsp_brightness_value
);
   import rgbhsv_pkg::*;

   // front stage to divider
   logic          fd_valid;
   logic          fd_ready;
   div_word_type  fd_word;
   // divider to output stages
   logic          db_valid;
   logic          db_ready;
   div_word_type  db_word;

   // max/min, branch pick, numerators and value
   rgbhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .out_valid (fd_valid),
      .out_ready (fd_ready),
      .out_word  (fd_word)
   );

   // three division lanes: saturation by max, two hue terms by span
   rgbhsv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fd_valid),
      .in_ready  (fd_ready),
      .in_word   (fd_word),
      .out_valid (db_valid),
      .out_ready (db_ready),
      .out_word  (db_word)
   );

   // hue scaling, sector offset, dark and grey handling, output register
   rgbhsv_back u_back (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (db_valid),
      .in_ready             (db_ready),
      .in_word              (db_word),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hue              (rsp_hue),
      .rsp_saturation       (rsp_saturation),
      .rsp_brightness_value (rsp_brightness_value)
   );

endmodule

### dv/rgb_to_hsv_integer_checker.sv
module rgb_to_hsv_integer_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [rgbhsv_pkg::ChW-1:0]   req_red,
   input  logic [rgbhsv_pkg::ChW-1:0]   req_green,
   input  logic [rgbhsv_pkg::ChW-1:0]   req_blue,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [rgbhsv_pkg::HueW-1:0]  rsp_hue,
   input  logic [rgbhsv_pkg::PctW-1:0]  rsp_saturation,
   input  logic [rgbhsv_pkg::PctW-1:0]  rsp_brightness_value,
   output int                           mismatch_count,
   output int                           words_pending,
   output int                           words_checked
);
   import rgbhsv_pkg::*;

   typedef struct packed {
      logic [ChW-1:0]  red;
      logic [ChW-1:0]  green;
      logic [ChW-1:0]  blue;
      logic [HueW-1:0] hue;
      logic [PctW-1:0] saturation;
      logic [PctW-1:0] brightness_value;
   } hsv_word_type;

   hsv_word_type hsv_expected_q[$];
   int mismatches = 0;
   int checked = 0;
   int pending = 0;

   assign mismatch_count = mismatches;
   assign words_checked  = checked;
   assign words_pending  = pending;

   function automatic hsv_word_type rgb_to_hsv_predict(input logic [ChW-1:0] r, g, b);
      hsv_word_type w;
      int rr, gg, bb, top, bot, span, h, s, v;
      rr = int'(r);
      gg = int'(g);
      bb = int'(b);
      top = rr;
      bot = rr;
      if (gg > top) top = gg;
      if (bb > top) top = bb;
      if (gg < bot) bot = gg;
      if (bb < bot) bot = bb;
      v = (top * 100) / 255;
      span = top - bot;
      h = 0;
      s = 0;
      if (v == 0) begin
         // dark pixel, everything zero
         v = 0;
      end else if (span != 0) begin
         s = (span * 100) / top;
         // first channel equal to the max picks the branch
         if (top == rr)
            h = ((((top - bb) * 100) / span - ((top - gg) * 100) / span) * 60) / 100;
         else if (top == gg)
            h = ((((top - rr) * 100) / span - ((top - bb) * 100) / span) * 60) / 100 + 120;
         else
            h = ((((top - gg) * 100) / span - ((top - rr) * 100) / span) * 60) / 100 + 240;
         if (h < 0) h += 360;
      end
      w.red = r;
      w.green = g;
      w.blue = b;
      w.hue = HueW'(h);
      w.saturation = PctW'(s);
      w.brightness_value = PctW'(v);
      return w;
   endfunction

   task automatic compare_field(input string field, input int want, input int got,
                                input hsv_word_type px);
      if (want != got) begin
         $display("%0t: %s mismatch for rgb (%0d,%0d,%0d): expected %0d, actual %0d",
                  $time, field, px.red, px.green, px.blue, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      hsv_word_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            hsv_expected_q.push_back(rgb_to_hsv_predict(req_red, req_green, req_blue));
         if (rsp_valid && rsp_ready) begin
            if (hsv_expected_q.size() == 0) begin
               $display("%0t: word with nothing expected: expected none, actual %0d/%0d/%0d",
                        $time, rsp_hue, rsp_saturation, rsp_brightness_value);
               mismatches++;
            end else begin
               want = hsv_expected_q.pop_front();
               checked++;
               compare_field("hue", int'(want.hue), int'(rsp_hue), want);
               compare_field("saturation", int'(want.saturation), int'(rsp_saturation),
                             want);
               compare_field("value", int'(want.brightness_value),
                             int'(rsp_brightness_value), want);
            end
         end
      end
      pending <= hsv_expected_q.size();
   end

endmodule

### dv/rgb_to_hsv_integer_tb.sv
module rgb_to_hsv_integer_tb;
   import rgbhsv_pkg::*;

   // generous bound on the whole run, in clock cycles
   localparam int CycleLimit  = 400000;
   // pipe is 10 deep, give it a few more before the verdict
   localparam int DrainCycles = 16;
   // long receiver hold-off, well beyond the pipe depth
   localparam int HoldCycles  = 60;
   localparam int PhaseWords  = 270;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [ChW-1:0]      req_red = '0;
   logic [ChW-1:0]      req_green = '0;
   logic [ChW-1:0]      req_blue = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [HueW-1:0]     rsp_hue;
   logic [PctW-1:0]     rsp_saturation;
   logic [PctW-1:0]     rsp_brightness_value;

   // idle and stall odds in percent, changed per phase
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // asks the receiver process for a long hold-off
   int hold_request   = 0;
   int cycle_count    = 0;
   int pixels_sent    = 0;
   int mismatch_count;
   int words_pending;
   int words_checked;

   rgb_to_hsv_integer i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_red              (req_red),
      .req_green            (req_green),
      .req_blue             (req_blue),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hue              (rsp_hue),
      .rsp_saturation       (rsp_saturation),
      .rsp_brightness_value (rsp_brightness_value)
   );

   // watches both channels, predicts each word and compares
   rgb_to_hsv_integer_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_red              (req_red),
      .req_green            (req_green),
      .req_blue             (req_blue),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hue              (rsp_hue),
      .rsp_saturation       (rsp_saturation),
      .rsp_brightness_value (rsp_brightness_value),
      .mismatch_count       (mismatch_count),
      .words_pending        (words_pending),
      .words_checked        (words_checked)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog: a hung pipe or a lost word ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver side: random stalls, or a counted hold-off on request
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // offer one pixel; valid stays up with the payload fixed until taken
   task automatic send_pixel(input logic [ChW-1:0] r, g, b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   // levels at the edges of the channel range
   function automatic logic [ChW-1:0] edge_level();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd127;
         3: return 8'd128;
         4: return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   // random pixel, weighted toward grey, dark, edge levels and max ties
   task automatic make_pixel(output logic [ChW-1:0] r, g, b);
      int base;
      logic [ChW-1:0] lvl;
      r = ChW'($urandom_range(255));
      g = ChW'($urandom_range(255));
      b = ChW'($urandom_range(255));
      case ($urandom_range(9))
         5, 6: begin
            // near grey: small spread around a random level
            base = int'($urandom_range(252));
            r = ChW'(base + int'($urandom_range(3)));
            g = ChW'(base + int'($urandom_range(3)));
            b = ChW'(base + int'($urandom_range(3)));
         end
         7: begin
            // around the dark threshold
            r = ChW'($urandom_range(5));
            g = ChW'($urandom_range(5));
            b = ChW'($urandom_range(5));
         end
         8: begin
            r = edge_level();
            g = edge_level();
            b = edge_level();
         end
         9: begin
            // two channels share the level, the third is free
            lvl = ChW'($urandom_range(255));
            case ($urandom_range(2))
               0: begin r = lvl; g = lvl; end
               1: begin g = lvl; b = lvl; end
               default: begin r = lvl; b = lvl; end
            endcase
         end
         default: ;
      endcase
   endtask

   task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
      logic [ChW-1:0] r, g, b;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         make_pixel(r, g, b);
         send_pixel(r, g, b);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners: black, white, dark and grey thresholds
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd2, 8'd2, 8'd2);
      send_pixel(8'd3, 8'd3, 8'd3);
      send_pixel(8'd2, 8'd0, 8'd1);
      send_pixel(8'd1, 8'd2, 8'd0);
      send_pixel(8'd3, 8'd0, 8'd0);
      // primaries and secondaries, the latter tie for the max
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      // red branch on both sides of zero, a negative hue wraps by a full circle
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd1, 8'd0);
      send_pixel(8'd200, 8'd10, 8'd150);
      // green and blue branches both ways
      send_pixel(8'd10, 8'd200, 8'd150);
      send_pixel(8'd150, 8'd200, 8'd10);
      send_pixel(8'd150, 8'd10, 8'd200);
      send_pixel(8'd10, 8'd150, 8'd200);
      // one step off grey, top and bottom, then a half-saturated red
      send_pixel(8'd128, 8'd128, 8'd127);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd170, 8'd85, 8'd85);

      // random pixels under each flow pattern
      run_phase(PhaseWords, 0, 0);
      run_phase(PhaseWords, 80, 0);
      run_phase(PhaseWords, 0, 80);
      run_phase(PhaseWords, 26, 26);
      // receiver holds off while the sender keeps pushing
      hold_request = HoldCycles;
      run_phase(PhaseWords, 0, 0);

      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (DrainCycles) @(posedge clock);

      $display("ran %0d pixels: corners, ties for the max, dark, grey and hue wrap cases,",
               pixels_sent);
      $display("random pixels under free flow, gaps, stalls and a long hold-off; %0d words checked",
               words_checked);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
